### rtl/pkrms_pkg.sv
`default_nettype none
package pkrms_pkg;

  localparam int KEY_W   = 4;
  localparam int LAT_W   = 24;
  localparam int TS_W    = 32;
  localparam int MEAN_W  = 32;
  localparam int VAR_W   = 64;
  localparam int CNT_W   = 32;
  localparam int WIDE_W  = 128;

  localparam int NUM_KEYS_DEF = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage
`default_nettype wire

### rtl/pkrms_in_if.sv
`default_nettype none
interface pkrms_in_if;
  logic                          valid;
  logic                          ready;
  logic [pkrms_pkg::KEY_W-1:0]   domain_key;
  logic [pkrms_pkg::LAT_W-1:0]   latency_us;
  logic [pkrms_pkg::TS_W-1:0]    timestamp;

  modport source (output valid, domain_key, latency_us, timestamp, input ready);
  modport sink   (input valid, domain_key, latency_us, timestamp, output ready);
endinterface
`default_nettype wire

### rtl/pkrms_out_if.sv
`default_nettype none
interface pkrms_out_if;
  logic                          valid;
  logic                          ready;
  logic [pkrms_pkg::KEY_W-1:0]   out_key;
  logic [pkrms_pkg::MEAN_W-1:0]  mean_latency;
  logic [pkrms_pkg::MEAN_W-1:0]  stdev_latency;
  logic [pkrms_pkg::CNT_W-1:0]   sample_count;
  logic [pkrms_pkg::TS_W-1:0]    first_time;
  logic [pkrms_pkg::TS_W-1:0]    last_time;

  modport source (output valid, out_key, mean_latency, stdev_latency, sample_count,
                  first_time, last_time, input ready);
  modport sink   (input valid, out_key, mean_latency, stdev_latency, sample_count,
                  first_time, last_time, output ready);
endinterface
`default_nettype wire

### rtl/pkrms_mul.sv
`default_nettype none
// Shared 32x32 multiplier with a registered product.
module pkrms_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire

### rtl/pkrms_div.sv
`default_nettype none
// Restoring divider, 128 by 64 bits, one quotient bit per cycle.
// A quotient that would not fit in 64 bits saturates to all ones.
module pkrms_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] dividend,
  input  wire logic [63:0]  divisor,
  output logic              done_r,
  output logic [63:0]       q_r
);
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] lo_r;
  logic [63:0] d_r;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem_r, lo_r[63]};
  assign take    = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r   <= divisor;
        rem_r <= dividend[127:64];
        lo_r  <= dividend[63:0];
        cnt_r <= 6'd63;
        if (dividend[127:64] >= divisor) begin
          q_r    <= {64{1'b1}};
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= take ? 64'(shifted - {1'b0, d_r}) : shifted[63:0];
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], take};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
`endif
endmodule
`default_nettype wire

### rtl/pkrms_sqrt.sv
`default_nettype none
// Integer square root of a 64-bit value, two radicand bits per cycle.
module pkrms_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done_r,
  output logic [31:0]      root_r
);
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [63:0] hold_r;
  logic [33:0] rem_r;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  assign rem_sh = {rem_r[31:0], rad_r[63:62]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        hold_r <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 5'd31;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
        rad_r <= {rad_r[61:0], 2'b00};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (66'(root_r) * 66'(root_r) <= 66'(hold_r)) &&
               ((66'(root_r) + 66'd1) * (66'(root_r) + 66'd1) > 66'(hold_r)))
    else $error("square root result is not the floor root");
`endif
endmodule
`default_nettype wire

### rtl/per_key_running_mean_stdev_top.sv
// Each accepted item runs a table read, multiplier passes, three divisions of up to 64 steps
// and one 32-step square root one after another, then the write back of the result.
// A new item is taken only from idle; it is taken the cycle after the result is
// loaded, later when a waiting result holds the write back until the receiver takes it.
// Reset (rst_n, synchronous, active low) starts a clearing pass over all NUM_KEYS entries.
`default_nettype none
module per_key_running_mean_stdev_top #(
  parameter int NUM_KEYS = pkrms_pkg::NUM_KEYS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pkrms_in_if.sink   in_ch,
  pkrms_out_if.source out_ch
);
  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // One table entry. The valid flag lives in the memory word, and the
  // clearing pass after reset zeroes every word.
  typedef struct packed {
    logic                            valid;
    logic [pkrms_pkg::MEAN_W-1:0]    mean;
    logic [pkrms_pkg::VAR_W-1:0]     variance;
    logic [pkrms_pkg::CNT_W-1:0]     count;
    logic [pkrms_pkg::TS_W-1:0]      first_time;
    logic [pkrms_pkg::TS_W-1:0]      last_time;
  } entry_t;

  // The sequencer walks through the update one step at a time. The mean
  // division, then the weighted squared deviation, then the variance
  // division share one multiplier and one divider; then the square root runs.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ,
    S_MM, S_MA, S_MS, S_MW,
    S_SQ, S_SQC, S_T0, S_T1, S_T2, S_TS, S_TW,
    S_V0, S_V1, S_V2, S_V3, S_VS, S_VW,
    S_QS, S_QW, S_OUT
  } state_t;

  state_t state_r;

  entry_t mem [NUM_KEYS];
  entry_t rd_r;

  logic [IDX_W-1:0] clr_idx_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] in_idx;
  logic [15:0]      key_ext;
  logic             key_ok;
  logic             in_fire;

  logic [pkrms_pkg::KEY_W-1:0]  key_r;
  logic [31:0]                  x_r;
  logic [pkrms_pkg::TS_W-1:0]   ts_r;
  logic [31:0]                  m_r;
  logic [63:0]                  v_r;
  logic [31:0]                  k_r;
  logic [31:0]                  n_r;
  logic [31:0]                  first_r;
  logic [31:0]                  d_r;
  logic [63:0]                  d2_r;
  logic [63:0]                  t_r;
  logic [31:0]                  mean_new_r;
  logic [63:0]                  var_new_r;
  logic [127:0]                 acc_r;

  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  mul_p;
  logic         div_start;
  logic         div_done;
  logic [63:0]  div_q;
  logic         sq_start;
  logic         sq_done;
  logic [31:0]  sq_root;

  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         out_free;
  logic         old_valid;
  logic [31:0]  old_cnt;
  logic [31:0]  k_sel;

  entry_t wr_entry;

  assign key_ext = 16'(in_ch.domain_key);
  assign in_idx  = key_ext[IDX_W-1:0];
  assign key_ok  = 32'(in_ch.domain_key) < 32'(NUM_KEYS);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Old count, with the saturated count treated as one below its maximum so
  // that the new count stays saturated.
  assign old_valid = rd_r.valid;
  assign old_cnt   = old_valid ? rd_r.count : 32'd0;
  assign k_sel     = (old_cnt == pkrms_pkg::CNT_MAX) ? (pkrms_pkg::CNT_MAX - 32'd1) : old_cnt;

  always_comb begin
    case (state_r)
      S_MM:    begin mul_a = m_r; mul_b = k_r;          end
      S_SQ:    begin mul_a = d_r; mul_b = d_r;          end
      S_T0:    begin mul_a = k_r; mul_b = d2_r[31:0];   end
      S_T1:    begin mul_a = k_r; mul_b = d2_r[63:32];  end
      S_V0:    begin mul_a = k_r; mul_b = v_r[31:0];    end
      S_V1:    begin mul_a = k_r; mul_b = v_r[63:32];   end
      default: begin mul_a = '0;  mul_b = '0;           end
    endcase
  end

  assign div_start = (state_r == S_MS) || (state_r == S_TS) || (state_r == S_VS);
  assign sq_start  = (state_r == S_QS);

  pkrms_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  pkrms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (64'(n_r)),
    .done_r   (div_done),
    .q_r      (div_q)
  );

  pkrms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (var_new_r),
    .done_r   (sq_done),
    .root_r   (sq_root)
  );

  always_comb begin
    wr_entry.valid      = 1'b1;
    wr_entry.mean       = mean_new_r;
    wr_entry.variance   = var_new_r;
    wr_entry.count      = n_r;
    wr_entry.first_time = first_r;
    wr_entry.last_time  = ts_r;
  end

  // The result register empties when the receiver takes it and fills when
  // the write back presents a new result; both can happen in one cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mem[clr_idx_r] <= '0;
    end else if (state_r == S_OUT && out_free) begin
      mem[idx_r] <= wr_entry;
    end
    if (in_fire) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == IDX_W'(NUM_KEYS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          // An item whose key is past the table is dropped without a result.
          if (in_fire && key_ok) begin
            idx_r   <= in_idx;
            key_r   <= in_ch.domain_key;
            x_r     <= {in_ch.latency_us, 8'd0};
            ts_r    <= in_ch.timestamp;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          m_r     <= old_valid ? rd_r.mean : 32'd0;
          v_r     <= old_valid ? rd_r.variance : 64'd0;
          first_r <= old_valid ? rd_r.first_time : ts_r;
          k_r     <= k_sel;
          n_r     <= k_sel + 32'd1;
          state_r <= S_MM;
        end
        S_MM: begin
          state_r <= S_MA;
        end
        S_MA: begin
          // m*k + x + n/2, rounding the mean half up.
          acc_r   <= 128'(mul_p) + 128'(x_r) + 128'(n_r >> 1);
          d_r     <= (x_r >= m_r) ? (x_r - m_r) : (m_r - x_r);
          state_r <= S_MS;
        end
        S_MS: begin
          state_r <= S_MW;
        end
        S_MW: begin
          if (div_done) begin
            mean_new_r <= (div_q[63:32] != 32'd0) ? pkrms_pkg::CNT_MAX : div_q[31:0];
            state_r    <= S_SQ;
          end
        end
        S_SQ: begin
          state_r <= S_SQC;
        end
        S_SQC: begin
          d2_r    <= mul_p;
          state_r <= S_T0;
        end
        S_T0: begin
          state_r <= S_T1;
        end
        S_T1: begin
          acc_r   <= 128'(mul_p);
          state_r <= S_T2;
        end
        S_T2: begin
          acc_r   <= acc_r + {32'd0, mul_p, 32'd0};
          state_r <= S_TS;
        end
        S_TS: begin
          state_r <= S_TW;
        end
        S_TW: begin
          if (div_done) begin
            t_r     <= div_q;
            state_r <= S_V0;
          end
        end
        S_V0: begin
          state_r <= S_V1;
        end
        S_V1: begin
          acc_r   <= 128'(mul_p);
          state_r <= S_V2;
        end
        S_V2: begin
          acc_r   <= acc_r + {32'd0, mul_p, 32'd0};
          state_r <= S_V3;
        end
        S_V3: begin
          acc_r   <= acc_r + 128'(t_r);
          state_r <= S_VS;
        end
        S_VS: begin
          state_r <= S_VW;
        end
        S_VW: begin
          if (div_done) begin
            var_new_r <= div_q;
            state_r   <= S_QS;
          end
        end
        S_QS: begin
          state_r <= S_QW;
        end
        S_QW: begin
          if (sq_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // The result register is loaded once the previous result is taken.
          if (out_free) begin
            out_ch.out_key       <= key_r;
            out_ch.mean_latency  <= mean_new_r;
            out_ch.stdev_latency <= sq_root;
            out_ch.sample_count  <= n_r;
            out_ch.first_time    <= first_r;
            out_ch.last_time     <= ts_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef SYNTH
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && key_ok) |=> (state_r == S_READ))
    else $error("accepted item did not start a table read");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.sample_count != 32'd0))
    else $error("result with zero sample count");
  a_write_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_ch.valid && state_r == S_IDLE))
    else $error("write back did not present a result");
`endif
endmodule
`default_nettype wire
